// ===== design/rmms_pkg.sv =====
// Shared constants, types and request records for the running statistics block.
package rmms_pkg;

	// Block configuration
	localparam int MAX_SAMPLES = 65536;
	localparam int CHANNELS    = 3;
	localparam int SAMPLE_BITS = 24;
	localparam int QUEUE_DEPTH = 2;

	// Field widths
	localparam int SMP_W  = 24;
	localparam int CH_W   = 2;
	localparam int CNT_W  = 17;
	localparam int BAND_W = 26;

	// Accumulator and arithmetic widths
	localparam int SUM_W    = 40;
	localparam int SQ_W     = 64;
	localparam int SQR_W    = 2 * SMP_W;
	localparam int DEN_W    = 2 * CNT_W;
	localparam int PROD_W   = CNT_W + SQ_W;
	localparam int ACC2_W   = 2 * SUM_W;
	localparam int QUO_W    = 2 * SAMPLE_BITS;
	localparam int ROOT_W   = SAMPLE_BITS;
	localparam int MAX_STEPS = (QUO_W > SUM_W) ? QUO_W : SUM_W;
	localparam int STEP_W   = $clog2(MAX_STEPS);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	// Port widths
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 168;
	localparam int OUT_USER_W = 1;
	localparam int OUT_PAD_W  = OUT_DATA_W - (4 * SMP_W + 2 * BAND_W + CNT_W);

	// Command codes
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_CLEAR,
		KIND_SKIP
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [CH_IDX_W-1:0]        channel;
		logic signed [SMP_W-1:0]    sample;
	} entry_t;

	typedef struct packed {
		logic                       start;
		logic [CNT_W-1:0]           n;
		logic signed [SUM_W-1:0]    s1;
		logic [SQ_W-1:0]            s2;
	} calc_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SMP_W-1:0]    mean;
		logic [SMP_W-1:0]           sd;
	} calc_rsp_t;

	typedef struct packed {
		logic                       full_res;
		logic [CNT_W-1:0]           sample_count;
		logic signed [BAND_W-1:0]   band_high;
		logic signed [BAND_W-1:0]   band_low;
		logic [SMP_W-1:0]           std_dev;
		logic signed [SMP_W-1:0]    mean;
		logic signed [SMP_W-1:0]    maximum;
		logic signed [SMP_W-1:0]    minimum;
	} result_t;

endpackage

// ===== design/rmms_fifo.sv =====
// Short request queue between the front and back parts.
module rmms_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rmms_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output rmms_pkg::entry_t rd_entry,
	output logic             empty
);

	rmms_pkg::entry_t               mem_q [rmms_pkg::QUEUE_DEPTH];
	logic [rmms_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [rmms_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [rmms_pkg::QCNT_W-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full     = (count_q == rmms_pkg::QCNT_W'(rmms_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rmms_pkg::QPTR_W'(rmms_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + rmms_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rmms_pkg::QPTR_W'(rmms_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + rmms_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + rmms_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - rmms_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== design/rmms_front.sv =====
// Front part: accept input requests, classify them and queue them.
module rmms_front (
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [rmms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [rmms_pkg::IN_USER_W-1:0]   s_axis_tuser,
	input  logic                             q_full,
	output logic                             q_push,
	output rmms_pkg::entry_t                 q_entry
);

	logic                                 command;
	logic [rmms_pkg::CH_W-1:0]            channel;
	logic signed [rmms_pkg::SAMPLE_BITS-1:0] sample_low;

	assign command    = s_axis_tuser[0];
	assign channel    = s_axis_tuser[2:1];
	assign sample_low = s_axis_tdata[rmms_pkg::SAMPLE_BITS-1:0];

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_entry.sample  = rmms_pkg::SMP_W'(sample_low);
		q_entry.channel = rmms_pkg::CH_IDX_W'(channel);
		if (command == rmms_pkg::CMD_CLEAR) begin
			q_entry.kind = rmms_pkg::KIND_CLEAR;
		end else if (32'(channel) >= rmms_pkg::CHANNELS) begin
			q_entry.kind = rmms_pkg::KIND_SKIP;
		end else begin
			q_entry.kind = rmms_pkg::KIND_ADD;
		end
	end

endmodule

// ===== design/rmms_calc.sv =====
// Bit-serial arithmetic unit: mean by division, deviation by division and square root.
module rmms_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmms_pkg::calc_req_t  req,
	output rmms_pkg::calc_rsp_t  rsp
);

	typedef enum logic [2:0] {
		C_IDLE,
		C_MUL,
		C_SUB,
		C_DIV,
		C_SQRT
	} calc_state_t;

	calc_state_t                          state_q;
	logic [rmms_pkg::STEP_W-1:0]          step_q;
	logic [rmms_pkg::CNT_W-1:0]           n_q;
	logic                                 neg_q;
	logic                                 small_q;
	logic [rmms_pkg::SUM_W-1:0]           mb1_q;
	logic [rmms_pkg::SUM_W-1:0]           a_q;
	logic [rmms_pkg::SUM_W-1:0]           mq_q;
	logic [rmms_pkg::CNT_W-1:0]           mr_q;
	logic [rmms_pkg::SQ_W-1:0]            s2_q;
	logic [rmms_pkg::PROD_W-1:0]          acc1_q;
	logic [rmms_pkg::ACC2_W-1:0]          acc2_q;
	logic [rmms_pkg::DEN_W-1:0]           d_q;
	logic [rmms_pkg::DEN_W-1:0]           vr_q;
	logic [rmms_pkg::QUO_W-1:0]           vq_q;
	logic [rmms_pkg::ROOT_W-1:0]          root_q;
	logic [rmms_pkg::ROOT_W:0]            sr_q;
	logic                                 done_q;
	logic signed [rmms_pkg::SMP_W-1:0]    mean_q;
	logic [rmms_pkg::SMP_W-1:0]           sd_q;

	logic [rmms_pkg::SUM_W-1:0]           s1_mag;
	logic [rmms_pkg::PROD_W-1:0]          mul1_add;
	logic [rmms_pkg::ACC2_W-1:0]          mul2_add;
	logic [rmms_pkg::CNT_W:0]             mtry;
	logic                                 mfit;
	logic [rmms_pkg::CNT_W:0]             mdiff;
	logic [rmms_pkg::DEN_W:0]             vtry;
	logic                                 vfit;
	logic [rmms_pkg::DEN_W:0]             vdiff;
	logic [rmms_pkg::ROOT_W+2:0]          stry;
	logic [rmms_pkg::ROOT_W+2:0]          strial;
	logic                                 sfit;
	logic [rmms_pkg::ROOT_W+2:0]          sdiff;
	logic [rmms_pkg::ROOT_W-1:0]          root_nx;
	logic [rmms_pkg::PROD_W-1:0]          num;
	logic [rmms_pkg::PROD_W-1:0]          num_hi;
	logic [rmms_pkg::SUM_W-1:0]           mean_full;

	always_comb begin
		s1_mag    = req.s1[rmms_pkg::SUM_W-1] ? rmms_pkg::SUM_W'(-req.s1) :
			rmms_pkg::SUM_W'(req.s1);
		mul1_add  = mb1_q[rmms_pkg::SUM_W-1] ? rmms_pkg::PROD_W'(s2_q) : '0;
		mul2_add  = mq_q[rmms_pkg::SUM_W-1] ? rmms_pkg::ACC2_W'(a_q) : '0;
		mtry      = {mr_q, mq_q[rmms_pkg::SUM_W-1]};
		mfit      = (mtry >= {1'b0, n_q});
		mdiff     = mtry - {1'b0, n_q};
		vtry      = {vr_q, vq_q[rmms_pkg::QUO_W-1]};
		vfit      = (vtry >= {1'b0, d_q});
		vdiff     = vtry - {1'b0, d_q};
		stry      = {sr_q, vq_q[rmms_pkg::QUO_W-1 -: 2]};
		strial    = {1'b0, root_q, 2'b01};
		sfit      = (stry >= strial);
		sdiff     = stry - strial;
		root_nx   = {root_q[rmms_pkg::ROOT_W-2:0], sfit};
		num       = acc1_q - rmms_pkg::PROD_W'(acc2_q);
		num_hi    = num >> rmms_pkg::QUO_W;
		mean_full = neg_q ? (~mq_q + rmms_pkg::SUM_W'(1)) : mq_q;
	end

	assign rsp.done = done_q;
	assign rsp.mean = mean_q;
	assign rsp.sd   = sd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			n_q     <= '0;
			neg_q   <= 1'b0;
			small_q <= 1'b0;
			mb1_q   <= '0;
			a_q     <= '0;
			mq_q    <= '0;
			mr_q    <= '0;
			s2_q    <= '0;
			acc1_q  <= '0;
			acc2_q  <= '0;
			d_q     <= '0;
			vr_q    <= '0;
			vq_q    <= '0;
			root_q  <= '0;
			sr_q    <= '0;
			done_q  <= 1'b0;
			mean_q  <= '0;
			sd_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						n_q     <= req.n;
						neg_q   <= req.s1[rmms_pkg::SUM_W-1];
						small_q <= (req.n < rmms_pkg::CNT_W'(2));
						mb1_q   <= rmms_pkg::SUM_W'(req.n);
						a_q     <= s1_mag;
						mq_q    <= s1_mag;
						mr_q    <= '0;
						s2_q    <= req.s2;
						acc1_q  <= '0;
						acc2_q  <= '0;
						step_q  <= rmms_pkg::STEP_W'(rmms_pkg::SUM_W - 1);
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					// Both products MSB first; the mean quotient shifts in behind |S1|
					acc1_q <= {acc1_q[rmms_pkg::PROD_W-2:0], 1'b0} + mul1_add;
					acc2_q <= {acc2_q[rmms_pkg::ACC2_W-2:0], 1'b0} + mul2_add;
					mb1_q  <= {mb1_q[rmms_pkg::SUM_W-2:0], 1'b0};
					mq_q   <= {mq_q[rmms_pkg::SUM_W-2:0], mfit};
					mr_q   <= mfit ? mdiff[rmms_pkg::CNT_W-1:0] : mtry[rmms_pkg::CNT_W-1:0];
					step_q <= step_q - rmms_pkg::STEP_W'(1);
					if (step_q == '0) begin
						state_q <= C_SUB;
					end
				end
				C_SUB: begin
					mean_q  <= mean_full[rmms_pkg::SMP_W-1:0];
					d_q     <= rmms_pkg::DEN_W'(n_q) * rmms_pkg::DEN_W'(n_q - rmms_pkg::CNT_W'(1));
					vr_q    <= num_hi[rmms_pkg::DEN_W-1:0];
					vq_q    <= num[rmms_pkg::QUO_W-1:0];
					root_q  <= '0;
					sr_q    <= '0;
					step_q  <= rmms_pkg::STEP_W'(rmms_pkg::QUO_W - 1);
					state_q <= C_DIV;
				end
				C_DIV: begin
					vq_q   <= {vq_q[rmms_pkg::QUO_W-2:0], vfit};
					vr_q   <= vfit ? vdiff[rmms_pkg::DEN_W-1:0] : vtry[rmms_pkg::DEN_W-1:0];
					step_q <= step_q - rmms_pkg::STEP_W'(1);
					if (step_q == '0) begin
						step_q  <= rmms_pkg::STEP_W'(rmms_pkg::ROOT_W - 1);
						state_q <= C_SQRT;
					end
				end
				C_SQRT: begin
					// Two radicand bits per step, one root bit out
					vq_q   <= {vq_q[rmms_pkg::QUO_W-3:0], 2'b00};
					sr_q   <= sfit ? sdiff[rmms_pkg::ROOT_W:0] : stry[rmms_pkg::ROOT_W:0];
					root_q <= root_nx;
					step_q <= step_q - rmms_pkg::STEP_W'(1);
					if (step_q == '0) begin
						sd_q    <= small_q ? '0 : rmms_pkg::SMP_W'(root_nx);
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/rmms_back.sv =====
// Back part: channel state, request execution and the result register.
module rmms_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  rmms_pkg::entry_t     q_head,
	output logic                 q_pop,
	output rmms_pkg::calc_req_t  calc_req,
	input  rmms_pkg::calc_rsp_t  calc_rsp,
	output logic                 res_valid,
	input  logic                 res_ready,
	output rmms_pkg::result_t    res
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_CALC,
		B_FIN
	} back_state_t;

	back_state_t                          state_q;
	rmms_pkg::entry_t                     cur_q;
	logic [rmms_pkg::SQR_W-1:0]           sq_s1;
	logic signed [rmms_pkg::SUM_W-1:0]    sum_q [rmms_pkg::CHANNELS];
	logic [rmms_pkg::SQ_W-1:0]            ssq_q [rmms_pkg::CHANNELS];
	logic signed [rmms_pkg::SMP_W-1:0]    min_q [rmms_pkg::CHANNELS];
	logic signed [rmms_pkg::SMP_W-1:0]    max_q [rmms_pkg::CHANNELS];
	logic [rmms_pkg::CNT_W-1:0]           cnt_q [rmms_pkg::CHANNELS];
	logic signed [rmms_pkg::SMP_W-1:0]    res_min_q;
	logic signed [rmms_pkg::SMP_W-1:0]    res_max_q;
	logic [rmms_pkg::CNT_W-1:0]           res_n_q;
	logic                                 res_full_q;
	logic                                 res_zero_q;
	rmms_pkg::calc_req_t                  req_q;
	logic                                 out_valid_q;
	rmms_pkg::result_t                    out_q;

	logic signed [rmms_pkg::SMP_W-1:0]    head_x;
	logic signed [rmms_pkg::SQR_W-1:0]    head_wide;
	logic signed [rmms_pkg::SMP_W-1:0]    x;
	logic [rmms_pkg::CH_IDX_W-1:0]        ch;
	logic [rmms_pkg::CNT_W-1:0]           cnt;
	logic                                 is_full;
	logic                                 is_first;
	logic signed [rmms_pkg::SMP_W-1:0]    new_min;
	logic signed [rmms_pkg::SMP_W-1:0]    new_max;
	logic signed [rmms_pkg::SUM_W-1:0]    new_sum;
	logic [rmms_pkg::SQ_W-1:0]            new_ssq;
	rmms_pkg::result_t                    fin;

	always_comb begin
		head_x    = q_head.sample;
		head_wide = rmms_pkg::SQR_W'(head_x);
		x         = cur_q.sample;
		ch        = cur_q.channel;
		cnt       = cnt_q[ch];
		is_full   = (cnt >= rmms_pkg::CNT_W'(rmms_pkg::MAX_SAMPLES));
		is_first  = (cnt == '0);
		new_min   = (is_first || (x < min_q[ch])) ? x : min_q[ch];
		new_max   = (is_first || (x > max_q[ch])) ? x : max_q[ch];
		new_sum   = sum_q[ch] + rmms_pkg::SUM_W'(x);
		new_ssq   = ssq_q[ch] + rmms_pkg::SQ_W'(sq_s1);
	end

	always_comb begin
		fin.minimum      = res_min_q;
		fin.maximum      = res_max_q;
		fin.mean         = calc_rsp.mean;
		fin.std_dev      = calc_rsp.sd;
		fin.band_low     = rmms_pkg::BAND_W'(calc_rsp.mean) - rmms_pkg::BAND_W'(calc_rsp.sd);
		fin.band_high    = rmms_pkg::BAND_W'(calc_rsp.mean) + rmms_pkg::BAND_W'(calc_rsp.sd);
		fin.sample_count = res_n_q;
		fin.full_res     = res_full_q;
		if (res_zero_q) begin
			fin = '0;
		end
	end

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign calc_req  = req_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cur_q       <= '0;
			sq_s1       <= '0;
			res_min_q   <= '0;
			res_max_q   <= '0;
			res_n_q     <= '0;
			res_full_q  <= 1'b0;
			res_zero_q  <= 1'b0;
			req_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int c = 0; c < rmms_pkg::CHANNELS; c++) begin
				sum_q[c] <= '0;
				ssq_q[c] <= '0;
				min_q[c] <= '0;
				max_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						cur_q   <= q_head;
						sq_s1   <= rmms_pkg::SQR_W'(head_wide * head_wide);
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					unique case (cur_q.kind)
						rmms_pkg::KIND_ADD: begin
							if (!is_full) begin
								sum_q[ch] <= new_sum;
								ssq_q[ch] <= new_ssq;
								min_q[ch] <= new_min;
								max_q[ch] <= new_max;
								cnt_q[ch] <= cnt + rmms_pkg::CNT_W'(1);
							end
							res_min_q   <= is_full ? min_q[ch] : new_min;
							res_max_q   <= is_full ? max_q[ch] : new_max;
							res_n_q     <= is_full ? cnt : cnt + rmms_pkg::CNT_W'(1);
							res_full_q  <= is_full;
							res_zero_q  <= 1'b0;
							req_q.start <= 1'b1;
							req_q.n     <= is_full ? cnt : cnt + rmms_pkg::CNT_W'(1);
							req_q.s1    <= is_full ? sum_q[ch] : new_sum;
							req_q.s2    <= is_full ? ssq_q[ch] : new_ssq;
							state_q     <= B_CALC;
						end
						rmms_pkg::KIND_CLEAR: begin
							for (int c = 0; c < rmms_pkg::CHANNELS; c++) begin
								sum_q[c] <= '0;
								ssq_q[c] <= '0;
								min_q[c] <= '0;
								max_q[c] <= '0;
								cnt_q[c] <= '0;
							end
							res_zero_q <= 1'b1;
							state_q    <= B_FIN;
						end
						default: begin
							res_zero_q <= 1'b1;
							state_q    <= B_FIN;
						end
					endcase
				end
				B_CALC: begin
					if (calc_rsp.done) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (!out_valid_q || res_ready) begin
						out_q       <= fin;
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/running_min_max_mean_std.sv =====
// Top level of the running minimum, maximum, mean and deviation block.
//
//  Channel  | Dir | Signals          | Contents (lowest bit first)
//  ---------+-----+------------------+-----------------------------------------------
//  s_axis   | in  | tdata[23:0]      | sample (Q12.12, signed)
//           |     | tuser[2:0]       | command, channel
//  m_axis   | out | tdata[167:0]     | minimum, maximum, mean, std_dev, band_low,
//           |     |                  | band_high, sample_count, zero padding
//           |     | tuser[0:0]       | full_res
//
// An add request spends most of its time from queue to result register in the bit-serial
// unit in rmms_calc (40 multiply/divide steps, 48 division steps for the variance, 24
// square-root steps); a clear or absent-channel request only passes the execute and finish
// states. One request is worked on at a time; the two-entry queue keeps taking requests
// meanwhile, and the result register lets the next request run while a result waits.
// Reset is asynchronous and empties every channel; no clearing pass follows it.
module running_min_max_mean_std (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input requests
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rmms_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // sample
	input  logic [rmms_pkg::IN_USER_W-1:0]    s_axis_tuser,   // command, channel
	// Results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [rmms_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // minimum, maximum, mean,
	                                                          // std_dev, band_low, band_high,
	                                                          // sample_count
	output logic [rmms_pkg::OUT_USER_W-1:0]   m_axis_tuser    // full_res
);

	logic                 q_full;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_empty;
	rmms_pkg::entry_t     q_in;
	rmms_pkg::entry_t     q_head;
	rmms_pkg::calc_req_t  calc_req;
	rmms_pkg::calc_rsp_t  calc_rsp;
	rmms_pkg::result_t    res;

	// Classify each request (add, clear, absent channel) and queue it
	rmms_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_in)
	);

	// Hold requests so the front keeps accepting while the back is busy
	rmms_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_head),
		.empty    (q_empty)
	);

	// Update channel state and register the result
	rmms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.calc_req  (calc_req),
		.calc_rsp  (calc_rsp),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Serial mean, variance and square root
	rmms_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.rsp    (calc_rsp)
	);

	// Pack the result fields, minimum in the lowest bits
	assign m_axis_tdata = {
		{rmms_pkg::OUT_PAD_W{1'b0}},
		res.sample_count,
		res.band_high,
		res.band_low,
		res.std_dev,
		res.mean,
		res.maximum,
		res.minimum
	};
	assign m_axis_tuser = res.full_res;

endmodule
